### sv/zsse_pkg.sv
package zsse_pkg;

    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [7:0]  ZLIB_CMF  = 8'h78;
    localparam logic [7:0]  ZLIB_FLG  = 8'h01;

    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] STEP_CMF     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_FLG     = 4'd1;
    localparam logic [STEP_W-1:0] STEP_BFINAL  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_LEN_LO  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_LEN_HI  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_NLEN_LO = 4'd5;
    localparam logic [STEP_W-1:0] STEP_NLEN_HI = 4'd6;
    localparam logic [STEP_W-1:0] STEP_DATA    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_B_HI    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_B_LO    = 4'd9;
    localparam logic [STEP_W-1:0] STEP_A_HI    = 4'd10;
    localparam logic [STEP_W-1:0] STEP_A_LO    = 4'd11;

    typedef struct packed {
        logic        hdr;
        logic        blk;
        logic        bfinal;
        logic [15:0] len;
        logic [7:0]  data;
        logic        last;
        logic [15:0] adler_hi;
        logic [15:0] adler_lo;
    } plan_t;

    typedef struct packed {
        logic busy;
        logic plan_ready;
    } emit_status_t;

endpackage

### sv/zsse_planner.sv
module zsse_planner #(
    parameter int MAX_BLOCK_BYTES = 65535
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [31:0]    cfg_wdata,
    input  logic           s_tvalid,
    input  logic [7:0]     s_tdata,
    input  logic           plan_ready,
    output logic           plan_valid,
    output zsse_pkg::plan_t plan
);
    import zsse_pkg::*;

    localparam logic [31:0] MaxLen = 32'(MAX_BLOCK_BYTES);

    logic [31:0] total_length_reg, total_length_next;
    logic        header_sent_reg, header_sent_next;
    logic [31:0] consumed_reg, consumed_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [15:0] low_reg, low_next;
    logic [15:0] high_reg, high_next;

    logic        active;
    logic        accept;
    logic [31:0] left;
    logic [15:0] len;
    logic        need_blk;
    logic [16:0] sum_low;
    logic [16:0] sum_high;
    logic [31:0] consumed_inc;

    always_comb begin
        active       = consumed_reg < total_length_reg;
        accept       = s_tvalid && plan_ready && active;
        left         = total_length_reg - consumed_reg;
        len          = (left > MaxLen) ? MaxLen[15:0] : left[15:0];
        need_blk     = remaining_reg == 16'd0;
        consumed_inc = consumed_reg + 32'd1;

        sum_low = {1'b0, low_reg} + {9'd0, s_tdata};
        if (sum_low >= ADLER_MOD) begin
            sum_low = sum_low - ADLER_MOD;
        end
        sum_high = {1'b0, high_reg} + sum_low;
        if (sum_high >= ADLER_MOD) begin
            sum_high = sum_high - ADLER_MOD;
        end

        plan.hdr      = !header_sent_reg;
        plan.blk      = need_blk;
        plan.bfinal   = left <= MaxLen;
        plan.len      = len;
        plan.data     = s_tdata;
        plan.last     = consumed_inc == total_length_reg;
        plan.adler_hi = sum_high[15:0];
        plan.adler_lo = sum_low[15:0];
        plan_valid    = accept;

        total_length_next = total_length_reg;
        header_sent_next  = header_sent_reg;
        consumed_next     = consumed_reg;
        remaining_next    = remaining_reg;
        low_next          = low_reg;
        high_next         = high_reg;

        if (cfg_we) begin
            total_length_next = cfg_wdata;
            header_sent_next  = 1'b0;
            consumed_next     = 32'd0;
            remaining_next    = 16'd0;
            low_next          = 16'd1;
            high_next         = 16'd0;
        end else if (accept) begin
            header_sent_next = 1'b1;
            consumed_next    = consumed_inc;
            remaining_next   = (need_blk ? len : remaining_reg) - 16'd1;
            low_next         = sum_low[15:0];
            high_next        = sum_high[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_length_reg <= 32'd1;
            header_sent_reg  <= 1'b0;
            consumed_reg     <= 32'd0;
            remaining_reg    <= 16'd0;
            low_reg          <= 16'd1;
            high_reg         <= 16'd0;
        end else begin
            total_length_reg <= total_length_next;
            header_sent_reg  <= header_sent_next;
            consumed_reg     <= consumed_next;
            remaining_reg    <= remaining_next;
            low_reg          <= low_next;
            high_reg         <= high_next;
        end
    end

endmodule

### sv/zsse_emitter.sv
module zsse_emitter (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   plan_valid,
    input  zsse_pkg::plan_t        plan,
    output zsse_pkg::emit_status_t status,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast,
    output logic [0:0]             m_tuser
);
    import zsse_pkg::*;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    plan_t             plan_reg, plan_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;
    logic              m_end_reg, m_end_next;

    logic              out_free;
    logic              emit;
    logic              item_end;
    logic              plan_ready;
    logic              load;
    logic [STEP_W-1:0] start_step;
    logic [STEP_W-1:0] after_step;
    logic [7:0]        cur_byte;
    logic [15:0]       nlen;

    always_comb begin
        nlen = ~plan_reg.len;

        unique case (step_reg)
            STEP_CMF:     cur_byte = ZLIB_CMF;
            STEP_FLG:     cur_byte = ZLIB_FLG;
            STEP_BFINAL:  cur_byte = {7'd0, plan_reg.bfinal};
            STEP_LEN_LO:  cur_byte = plan_reg.len[7:0];
            STEP_LEN_HI:  cur_byte = plan_reg.len[15:8];
            STEP_NLEN_LO: cur_byte = nlen[7:0];
            STEP_NLEN_HI: cur_byte = nlen[15:8];
            STEP_DATA:    cur_byte = plan_reg.data;
            STEP_B_HI:    cur_byte = plan_reg.adler_hi[15:8];
            STEP_B_LO:    cur_byte = plan_reg.adler_hi[7:0];
            STEP_A_HI:    cur_byte = plan_reg.adler_lo[15:8];
            STEP_A_LO:    cur_byte = plan_reg.adler_lo[7:0];
            default:      cur_byte = 8'd0;
        endcase

        priority if (step_reg == STEP_FLG) begin
            after_step = plan_reg.blk ? STEP_BFINAL : STEP_DATA;
        end else begin
            after_step = step_reg + STEP_W'(1);
        end

        priority if (plan.hdr) begin
            start_step = STEP_CMF;
        end else if (plan.blk) begin
            start_step = STEP_BFINAL;
        end else begin
            start_step = STEP_DATA;
        end

        item_end   = (step_reg == STEP_A_LO) || (step_reg == STEP_DATA && !plan_reg.last);
        out_free   = !m_valid_reg || m_tready;
        emit       = busy_reg && out_free;
        plan_ready = !busy_reg || (emit && item_end);
        load       = plan_valid && plan_ready;

        busy_next = busy_reg;
        step_next = step_reg;
        plan_next = plan_reg;
        if (load) begin
            busy_next = 1'b1;
            step_next = start_step;
            plan_next = plan;
        end else if (emit) begin
            busy_next = !item_end;
            step_next = after_step;
        end

        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_end_next   = m_end_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = cur_byte;
            m_last_next  = item_end;
            m_end_next   = step_reg == STEP_A_LO;
        end

        status.busy       = busy_reg;
        status.plan_ready = plan_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            step_reg    <= STEP_CMF;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
        plan_reg   <= plan_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_end_reg  <= m_end_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_end_reg;

endmodule

### sv/zlib_stored_stream_encoder.sv
// zlib encoder over stored deflate blocks.
// Write the stream length (raw bytes) on cfg_we/cfg_wdata while idle; each
// write restarts the stream. Feed raw bytes on the s_ channel, one item per
// byte; bytes past the configured length are taken and dropped.
// The m_ channel carries the zlib stream one byte per item: the header
// 78 01 ahead of the first byte, a five-byte stored block header at the
// start of each block, the data byte, and after the final byte the Adler-32
// big-endian. m_tlast marks the last byte caused by one input item and
// m_tuser marks the last byte of the whole stream.
// An accepted item goes to the sequencer's plan register, then its bytes pass
// through the output register. Throughput: one output byte per cycle while
// m_tready does not stall, set by the byte sequencer; a plain data item gives
// one byte, one that opens a block six (eight with the stream header), the last four more.
// The next item is taken in the cycle the current item's last byte moves
// to the output register, so items flow back to back.
// Reset (aresetn low, synchronous) sets the length to 1 and clears the
// stream state and the output valid flag. A stall on m_tready holds the
// output byte and, once the sequencer has no free slot, drops s_tready.
module zlib_stored_stream_encoder #(
    parameter int MAX_BLOCK_BYTES = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // [0] stream_end
);
    import zsse_pkg::*;

    logic         plan_valid;
    plan_t        plan;
    emit_status_t status;

    zsse_planner #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
    ) u_planner (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tdata    (s_tdata),
        .plan_ready (status.plan_ready),
        .plan_valid (plan_valid),
        .plan       (plan)
    );

    zsse_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .plan_valid (plan_valid),
        .plan       (plan),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    assign s_tready = status.plan_ready;

    a_end_is_item_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("stream end byte without item last mark");

    a_plan_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        plan_valid |=> status.busy)
        else $error("accepted item not loaded into sequencer");

    a_idle_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser[0] |-> !status.busy)
        else $error("sequencer busy after stream end");

    a_ready_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !status.busy |-> s_tready)
        else $error("input stalled with idle sequencer");

endmodule

### test/zsse_stream_checker.sv
`timescale 1ns / 1ps

module zsse_stream_checker
    import zsse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    input  logic [0:0]  m_tuser,
    output int          fail_count,
    output int          pending
);

    localparam logic [31:0] BLOCK_MAX = 32'd65535;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_end;
    } zbyte_t;

    zbyte_t      zlib_bytes_q[$];
    int          errs = 0;

    logic [31:0] total_len;
    logic        hdr_done;
    logic [31:0] consumed;
    logic [15:0] blk_left;
    logic [15:0] a_lo;
    logic [15:0] a_hi;

    function automatic zbyte_t plain(input logic [7:0] b);
        zbyte_t z;
        z.out_byte   = b;
        z.run_last   = 1'b0;
        z.stream_end = 1'b0;
        return z;
    endfunction

    task automatic restart_stream();
        hdr_done = 1'b0;
        consumed = '0;
        blk_left = '0;
        a_lo     = 16'd1;
        a_hi     = 16'd0;
    endtask

    task automatic encode_raw_byte(input logic [7:0] din);
        zbyte_t      run_buf[12];
        int          n;
        logic [31:0] left;
        logic [15:0] blen;
        logic [15:0] nlen;
        logic [31:0] sum;
        n = 0;
        if (consumed >= total_len) return;
        if (!hdr_done) begin
            run_buf[n++] = plain(ZLIB_CMF);
            run_buf[n++] = plain(ZLIB_FLG);
            hdr_done = 1'b1;
        end
        if (blk_left == 16'd0) begin
            left = total_len - consumed;
            blen = (left > BLOCK_MAX) ? BLOCK_MAX[15:0] : left[15:0];
            nlen = ~blen;
            run_buf[n++] = plain({7'd0, (left <= BLOCK_MAX)});
            run_buf[n++] = plain(blen[7:0]);
            run_buf[n++] = plain(blen[15:8]);
            run_buf[n++] = plain(nlen[7:0]);
            run_buf[n++] = plain(nlen[15:8]);
            blk_left = blen;
        end
        run_buf[n++] = plain(din);
        blk_left = blk_left - 16'd1;
        consumed = consumed + 32'd1;
        sum  = {16'd0, a_lo} + {24'd0, din};
        a_lo = 16'(sum % ADLER_MOD);
        sum  = {16'd0, a_hi} + {16'd0, a_lo};
        a_hi = 16'(sum % ADLER_MOD);
        if (consumed == total_len) begin
            run_buf[n++] = plain(a_hi[15:8]);
            run_buf[n++] = plain(a_hi[7:0]);
            run_buf[n++] = plain(a_lo[15:8]);
            run_buf[n++] = plain(a_lo[7:0]);
            run_buf[n-1].stream_end = 1'b1;
        end
        run_buf[n-1].run_last = 1'b1;
        for (int i = 0; i < n; i++) zlib_bytes_q.push_back(run_buf[i]);
    endtask

    always @(posedge aclk) begin
        zbyte_t want;
        if (!aresetn) begin
            total_len = 32'd1;
            restart_stream();
            zlib_bytes_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (zlib_bytes_q.size() == 0) begin
                    $display("%0t unexpected item: expected none, got byte %02h last %0b end %0b",
                             $time, m_tdata, m_tlast, m_tuser[0]);
                    errs++;
                end else begin
                    want = zlib_bytes_q.pop_front();
                    if (m_tdata !== want.out_byte) begin
                        $display("%0t out_byte: expected %02h, got %02h",
                                 $time, want.out_byte, m_tdata);
                        errs++;
                    end
                    if (m_tlast !== want.run_last) begin
                        $display("%0t run_last: expected %0b, got %0b",
                                 $time, want.run_last, m_tlast);
                        errs++;
                    end
                    if (m_tuser[0] !== want.stream_end) begin
                        $display("%0t stream_end: expected %0b, got %0b",
                                 $time, want.stream_end, m_tuser[0]);
                        errs++;
                    end
                end
            end
            if (cfg_we) begin
                total_len = cfg_wdata;
                restart_stream();
            end
            if (s_tvalid && s_tready) encode_raw_byte(s_tdata);
        end
        fail_count <= errs;
        pending    <= zlib_bytes_q.size();
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = 32'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    int          fails;
    int          pending;
    logic        calm = 1'b0;

    zlib_stored_stream_encoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    zsse_stream_checker chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .fail_count(fails),
        .pending   (pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap(input logic quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet) return (r < 97) ? 0 : $urandom_range(1, 3);
        if (r < 50) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 8'h00;
        if (r < 30) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // random stalls on the result side
    initial begin
        int gap;
        int run;
        forever begin
            gap = pick_gap(calm);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            run = calm ? $urandom_range(50, 400) :
                  ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) :
                  $urandom_range(1, 8);
            repeat (run) @(posedge aclk);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold until every predicted byte has left, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_length(input logic [31:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int          counted;
        int          nsend;
        int          extra;
        int          r;
        logic [31:0] plen;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset length of one: full stream from a single item, then ignored items
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        drain();

        // zero length: everything dropped
        write_length(32'd0);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);
        drain();

        // maximum length: first block is non-final and full size
        write_length(32'hFFFF_FFFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h01);
        drain();

        write_length(32'd2);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h7F);
        drain();

        counted = 0;
        while (counted < 160) begin
            r = $urandom_range(0, 99);
            if (r < 8) plen = 32'd0;
            else if (r < 18) plen = $urandom;
            else plen = 32'($urandom_range(1, 12));
            write_length(plen);
            nsend = (plen > 32'd12) ? $urandom_range(1, 6) : int'(plen);
            if (plen > 32'd1 && plen <= 32'd12 && $urandom_range(0, 4) == 0)
                nsend = $urandom_range(1, int'(plen) - 1);
            for (int i = 0; i < nsend; i++) send_byte(rand_byte());
            counted += nsend;
            extra = 0;
            if (plen == 32'd0) extra = $urandom_range(1, 3);
            else if (32'(nsend) == plen && $urandom_range(0, 3) == 0)
                extra = $urandom_range(1, 2);
            for (int i = 0; i < extra; i++) send_byte(rand_byte());
            drain();
        end

        if (fails == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
